// ===== rtl/core/table_traffic_injection_decider_unit_macros.svh =====
// Assertion helpers shared by the decider RTL.
`ifndef TABLE_TRAFFIC_INJECTION_DECIDER_UNIT_MACROS_SVH
`define TABLE_TRAFFIC_INJECTION_DECIDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTID_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttid check failed");

// Next-cycle implication, checked outside reset.
`define TTID_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttid check failed");

`endif

// ===== rtl/core/ttid_pkg.sv =====
package ttid_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int NODE_BITS         = 8;
  localparam int RATE_FRAC_BITS    = 16;

  localparam int CFG_W    = 5;
  localparam int INDEX_W  = 4;
  localparam int SRC_W    = 8;
  localparam int RATE_W   = 17;
  localparam int TIME_W   = 31;
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 20;

  localparam int NODE_CMP_W = (NODE_BITS < SRC_W) ? NODE_BITS : SRC_W;

  localparam logic [31:0] RATE_ONE = 32'(1) << RATE_FRAC_BITS;
  localparam logic [THR_W-1:0] THRESH_MAX = {THR_W{1'b1}};

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int OFS_INDEX   = 0;
  localparam int OFS_SOURCE  = OFS_INDEX + INDEX_W;
  localparam int OFS_INJECT  = OFS_SOURCE + SRC_W;
  localparam int OFS_RETRY   = OFS_INJECT + RATE_W;
  localparam int OFS_ON      = OFS_RETRY + RATE_W;
  localparam int OFS_OFF     = OFS_ON + TIME_W;
  localparam int OFS_PERIOD  = OFS_OFF + TIME_W;
  localparam int OFS_NODE    = OFS_PERIOD + TIME_W;
  localparam int OFS_TIME    = OFS_NODE + SRC_W;
  localparam int OFS_RETX    = OFS_TIME + TIME_W;
  localparam int OFS_SAMPLE  = OFS_RETX + 1;
  localparam int S_USED_W    = OFS_SAMPLE + SAMPLE_W;
  localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

  localparam int M_USED_W  = 1 + THR_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic busy;
    logic done;
  } ttid_div_st_t;

endpackage

// ===== rtl/core/ttid_rem.sv =====
`include "table_traffic_injection_decider_unit_macros.svh"

module ttid_rem
  import ttid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output ttid_div_st_t      st,
  output logic [TIME_W-1:0] rem
);

  localparam int STEP_W = $clog2(TIME_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [TIME_W-1:0] quo;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quo[TIME_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[TIME_W-2:0], 1'b0};
      if (fits) begin
        rem <= TIME_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[TIME_W-1:0];
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;

  `TTID_ASSERT_IMP(a_start_when_free, clk, rst, start, !busy)
  `TTID_ASSERT_IMP(a_rem_below_divisor, clk, rst, done && (dvs != '0), rem < dvs)
  `TTID_ASSERT_NEXT(a_last_step_done, clk, rst, busy && (cnt == STEP_W'(1)), done && !busy)

endmodule

// ===== rtl/core/table_traffic_injection_decider_unit.sv =====
// Load item: ready again in the next cycle; no result.
// Query item: each walked entry passes ST_FETCH and ST_MATCH; a matching entry then waits in ST_DIV
// for the 31-step serial remainder unit that computes the phase, then passes ST_ACC; ST_DONE finishes.
// One item in work at a time; the result register lets the next item in while a result waits.
// Reset (synchronous, active high) clears entry_count, the sequencer and the result valid;
// the entry table is not cleared and holds no meaning until each slot is loaded.
`include "table_traffic_injection_decider_unit_macros.svh"

module table_traffic_injection_decider_unit
  import ttid_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_index, entry_source, entry_inject_rate, entry_retry_rate, entry_on_time,
  // entry_off_time, entry_period, query_node, cycle_time, retransmit, random_sample
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fire, threshold
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_MATCH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [SRC_W-1:0]  tab_source [TABLE_ENTRIES];
  logic [RATE_W-1:0] tab_inject [TABLE_ENTRIES];
  logic [RATE_W-1:0] tab_retry  [TABLE_ENTRIES];
  logic [TIME_W-1:0] tab_on     [TABLE_ENTRIES];
  logic [TIME_W-1:0] tab_off    [TABLE_ENTRIES];
  logic [TIME_W-1:0] tab_period [TABLE_ENTRIES];

  logic [2:0]          state;
  logic [CFG_W-1:0]    cfg_count;
  logic [CNT_W-1:0]    walk;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    idx_inc;
  logic [CNT_W-1:0]    walk_next;
  logic                idx_last;

  logic [SRC_W-1:0]    node_q;
  logic [TIME_W-1:0]   time_q;
  logic                retry_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SRC_W-1:0]    e_src;
  logic [RATE_W-1:0]   e_rate;
  logic [TIME_W-1:0]   e_on;
  logic [TIME_W-1:0]   e_off;
  logic [TIME_W-1:0]   e_period;
  logic [THR_W-1:0]    thr;
  logic                out_fire;
  logic [THR_W-1:0]    out_thr;

  logic                in_acc;
  logic                load_acc;
  logic                query_acc;
  logic                slot_ok;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic                src_match;
  logic                div_start;
  ttid_div_st_t        div_st;
  logic [TIME_W-1:0]   phase;
  logic                phase_on;
  logic [31:0]         rate_clamped;
  logic [THR_W:0]      thr_sum;
  logic                out_free;

  logic [INDEX_W-1:0]  in_index;
  logic [SRC_W-1:0]    in_source;
  logic [RATE_W-1:0]   in_inject;
  logic [RATE_W-1:0]   in_retry;
  logic [TIME_W-1:0]   in_on;
  logic [TIME_W-1:0]   in_off;
  logic [TIME_W-1:0]   in_period;
  logic [SRC_W-1:0]    in_node;
  logic [TIME_W-1:0]   in_time;
  logic                in_retx;
  logic [SAMPLE_W-1:0] in_sample;

  assign in_index  = s_axis_tdata[OFS_INDEX +: INDEX_W];
  assign in_source = s_axis_tdata[OFS_SOURCE +: SRC_W];
  assign in_inject = s_axis_tdata[OFS_INJECT +: RATE_W];
  assign in_retry  = s_axis_tdata[OFS_RETRY +: RATE_W];
  assign in_on     = s_axis_tdata[OFS_ON +: TIME_W];
  assign in_off    = s_axis_tdata[OFS_OFF +: TIME_W];
  assign in_period = s_axis_tdata[OFS_PERIOD +: TIME_W];
  assign in_node   = s_axis_tdata[OFS_NODE +: SRC_W];
  assign in_time   = s_axis_tdata[OFS_TIME +: TIME_W];
  assign in_retx   = s_axis_tdata[OFS_RETX];
  assign in_sample = s_axis_tdata[OFS_SAMPLE +: SAMPLE_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_acc      = in_acc && (s_axis_tuser[0] == FUNC_LOAD);
  assign query_acc     = in_acc && (s_axis_tuser[0] == FUNC_QUERY);
  assign slot_ok       = ({{(32 - INDEX_W){1'b0}}, in_index} < 32'(TABLE_ENTRIES));
  assign wr_addr       = IDX_W'(in_index);
  assign rd_addr       = idx[IDX_W-1:0];

  assign walk_next = ({{(32 - CFG_W){1'b0}}, cfg_count} > 32'(TABLE_ENTRIES)) ?
                     CNT_W'(TABLE_ENTRIES) : CNT_W'(cfg_count);
  assign idx_inc   = idx + 1'b1;
  assign idx_last  = (idx_inc == walk);

  assign src_match = (e_src[NODE_CMP_W-1:0] == node_q[NODE_CMP_W-1:0]);
  assign div_start = (state == ST_MATCH) && src_match;
  assign phase_on  = (phase > e_on) && (phase < e_off);

  assign rate_clamped = ({15'b0, e_rate} > RATE_ONE) ? RATE_ONE : {15'b0, e_rate};
  assign thr_sum      = {1'b0, thr} + (THR_W + 1)'(rate_clamped);
  assign out_free     = !m_axis_tvalid || m_axis_tready;

  ttid_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (time_q),
    .divisor  (e_period),
    .st       (div_st),
    .rem      (phase)
  );

  always_ff @(posedge clk) begin
    if (load_acc && slot_ok) begin
      tab_source[wr_addr] <= in_source;
      tab_inject[wr_addr] <= in_inject;
      tab_retry[wr_addr]  <= in_retry;
      tab_on[wr_addr]     <= in_on;
      tab_off[wr_addr]    <= in_off;
      tab_period[wr_addr] <= in_period;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      e_src    <= tab_source[rd_addr];
      e_rate   <= retry_q ? tab_retry[rd_addr] : tab_inject[rd_addr];
      e_on     <= tab_on[rd_addr];
      e_off    <= tab_off[rd_addr];
      e_period <= tab_period[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cfg_count <= '0;
      walk      <= '0;
      idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (query_acc) begin
            walk  <= walk_next;
            idx   <= '0;
            state <= (walk_next == '0) ? ST_DONE : ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_MATCH;
        end
        ST_MATCH: begin
          if (src_match) begin
            state <= ST_DIV;
          end else begin
            idx   <= idx_inc;
            state <= idx_last ? ST_DONE : ST_FETCH;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          idx   <= idx_inc;
          state <= idx_last ? ST_DONE : ST_FETCH;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      node_q   <= in_node;
      time_q   <= in_time;
      retry_q  <= in_retx;
      sample_q <= in_sample;
      thr      <= '0;
    end else if ((state == ST_ACC) && phase_on) begin
      thr <= thr_sum[THR_W] ? THRESH_MAX : thr_sum[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_fire <= ({{(THR_W - SAMPLE_W){1'b0}}, sample_q} < thr);
      out_thr  <= thr;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_thr, out_fire};

  `TTID_ASSERT_IMP(a_div_done_in_div, clk, rst, div_st.done, state == ST_DIV)
  `TTID_ASSERT_IMP(a_div_busy_in_div, clk, rst, div_st.busy, state == ST_DIV)
  `TTID_ASSERT_IMP(a_idx_in_walk, clk, rst, state != ST_IDLE, idx <= walk)
  `TTID_ASSERT_NEXT(a_thr_no_drop, clk, rst, state == ST_ACC, thr >= $past(thr))

endmodule

// ===== verif/injection_decision_checker.sv =====
module injection_decision_checker
  import ttid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   fail_count,
  output int                   outstanding
);

  // threshold above fire, so fire lands in bit 0
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             fire;
  } decision_t;

  logic [SRC_W-1:0]  src_tab    [TABLE_ENTRIES_DEF];
  logic [RATE_W-1:0] inject_tab [TABLE_ENTRIES_DEF];
  logic [RATE_W-1:0] retry_tab  [TABLE_ENTRIES_DEF];
  logic [TIME_W-1:0] on_tab     [TABLE_ENTRIES_DEF];
  logic [TIME_W-1:0] off_tab    [TABLE_ENTRIES_DEF];
  logic [TIME_W-1:0] period_tab [TABLE_ENTRIES_DEF];
  logic [CFG_W-1:0]  walk_count;
  decision_t         pending_decisions[$];

  function automatic decision_t decide_injection(input logic [SRC_W-1:0] node,
                                                 input logic [TIME_W-1:0] now,
                                                 input logic retx,
                                                 input logic [SAMPLE_W-1:0] sample);
    decision_t         d;
    logic [31:0]       sum;
    logic [31:0]       rate;
    logic [TIME_W-1:0] phase;
    int                walk;
    walk = (walk_count > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : int'(walk_count);
    sum = '0;
    for (int i = 0; i < walk; i++) begin
      if (src_tab[i][NODE_CMP_W-1:0] == node[NODE_CMP_W-1:0]) begin
        phase = (period_tab[i] == '0) ? now : now % period_tab[i];
        if (phase > on_tab[i] && phase < off_tab[i]) begin
          rate = retx ? 32'(retry_tab[i]) : 32'(inject_tab[i]);
          if (rate > RATE_ONE) rate = RATE_ONE;
          sum = sum + rate;
          if (sum > 32'(THRESH_MAX)) sum = 32'(THRESH_MAX);
        end
      end
    end
    d.fire      = (32'(sample) < sum);
    d.threshold = sum[THR_W-1:0];
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    decision_t got;
    decision_t want;
    decision_t predicted;
    int        idx;
    if (rst) begin
      walk_count = '0;
      pending_decisions.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) walk_count = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got = decision_t'(m_axis_tdata[M_USED_W-1:0]);
        if (pending_decisions.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), '0);
        end else begin
          want = pending_decisions.pop_front();
          if (got.fire !== want.fire) report_mismatch("fire", 32'(got.fire), 32'(want.fire));
          if (got.threshold !== want.threshold)
            report_mismatch("threshold", 32'(got.threshold), 32'(want.threshold));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == FUNC_LOAD) begin
          idx = int'(s_axis_tdata[OFS_INDEX +: INDEX_W]);
          if (idx < TABLE_ENTRIES_DEF) begin
            src_tab[idx]    = s_axis_tdata[OFS_SOURCE +: SRC_W];
            inject_tab[idx] = s_axis_tdata[OFS_INJECT +: RATE_W];
            retry_tab[idx]  = s_axis_tdata[OFS_RETRY +: RATE_W];
            on_tab[idx]     = s_axis_tdata[OFS_ON +: TIME_W];
            off_tab[idx]    = s_axis_tdata[OFS_OFF +: TIME_W];
            period_tab[idx] = s_axis_tdata[OFS_PERIOD +: TIME_W];
          end
        end else begin
          predicted = decide_injection(s_axis_tdata[OFS_NODE +: SRC_W],
                                       s_axis_tdata[OFS_TIME +: TIME_W],
                                       s_axis_tdata[OFS_RETX],
                                       s_axis_tdata[OFS_SAMPLE +: SAMPLE_W]);
          pending_decisions.insert(pending_decisions.size(), predicted);
        end
      end
      outstanding = pending_decisions.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  import ttid_pkg::*;

  localparam int LONG_HOLD      = 1500;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam int DRAIN_CYCLES   = 600;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  bit hold_req    = 1'b0;

  logic [SRC_W-1:0] node_pool [4] = '{8'd5, 8'd6, 8'd200, 8'd255};
  int               count_plan [PHASES] = '{16, 0, 31, 16, 1, 17, -1, 16, -1, 16};

  always #5 clk = ~clk;

  table_traffic_injection_decider_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  injection_decision_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink: random stall per item while sink_stalls is set, one long hold on request
  initial begin
    int w;
    bit held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      w = sink_stalls ? $urandom_range(0, 16) : 0;
      if (hold_req && !held) begin
        held = 1'b1;
        w = LONG_HOLD;
      end
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [S_TDATA_W-1:0] noise_fields();
    logic [S_TDATA_W-1:0] d;
    d = '0;
    for (int k = 0; k < S_USED_W; k++) d[k] = 1'($urandom_range(0, 1));
    return d;
  endfunction

  task automatic send_item(input logic func, input logic [S_TDATA_W-1:0] data);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_entry_count(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [SRC_W-1:0] src,
                            input logic [RATE_W-1:0] inject, input logic [RATE_W-1:0] retry,
                            input logic [TIME_W-1:0] on_t, input logic [TIME_W-1:0] off_t,
                            input logic [TIME_W-1:0] per);
    logic [S_TDATA_W-1:0] d;
    d = noise_fields();
    d[OFS_INDEX +: INDEX_W]  = idx;
    d[OFS_SOURCE +: SRC_W]   = src;
    d[OFS_INJECT +: RATE_W]  = inject;
    d[OFS_RETRY +: RATE_W]   = retry;
    d[OFS_ON +: TIME_W]      = on_t;
    d[OFS_OFF +: TIME_W]     = off_t;
    d[OFS_PERIOD +: TIME_W]  = per;
    send_item(FUNC_LOAD, d);
  endtask

  task automatic ask(input logic [SRC_W-1:0] node, input logic [TIME_W-1:0] now,
                     input logic retx, input logic [SAMPLE_W-1:0] sample);
    logic [S_TDATA_W-1:0] d;
    d = noise_fields();
    d[OFS_NODE +: SRC_W]       = node;
    d[OFS_TIME +: TIME_W]      = now;
    d[OFS_RETX]                = retx;
    d[OFS_SAMPLE +: SAMPLE_W]  = sample;
    send_item(FUNC_QUERY, d);
  endtask

  task automatic random_load();
    logic [S_TDATA_W-1:0] d;
    logic [TIME_W-1:0]    per;
    logic [TIME_W-1:0]    on_t;
    d = noise_fields();
    if ($urandom_range(0, 6) != 0) d[OFS_SOURCE +: SRC_W] = node_pool[2'($urandom_range(0, 3))];
    if ($urandom_range(0, 7) != 0) d[OFS_INJECT +: RATE_W] = RATE_W'($urandom_range(0, 65536));
    if ($urandom_range(0, 7) != 0) d[OFS_RETRY +: RATE_W] = RATE_W'($urandom_range(0, 65536));
    case ($urandom_range(0, 9))
      0: begin
      end
      1: begin
        d[OFS_PERIOD +: TIME_W] = '0;
        d[OFS_ON +: TIME_W]     = TIME_W'($urandom_range(0, 64));
      end
      default: begin
        per  = TIME_W'($urandom_range(1, 64));
        on_t = TIME_W'($urandom_range(0, per));
        d[OFS_PERIOD +: TIME_W] = per;
        d[OFS_ON +: TIME_W]     = on_t;
        d[OFS_OFF +: TIME_W]    = TIME_W'($urandom_range(on_t, per + 1));
      end
    endcase
    send_item(FUNC_LOAD, d);
  endtask

  task automatic random_query();
    logic [S_TDATA_W-1:0] d;
    d = noise_fields();
    if ($urandom_range(0, 6) != 0) d[OFS_NODE +: SRC_W] = node_pool[2'($urandom_range(0, 3))];
    if ($urandom_range(0, 1) != 0) d[OFS_TIME +: TIME_W] = TIME_W'($urandom_range(0, 1000));
    send_item(FUNC_QUERY, d);
  endtask

  initial begin
    int count;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty walk right after reset
    ask(8'd0, '0, 1'b0, '0);
    ask(8'd255, TIME_MAX, 1'b1, 16'hFFFF);

    // fill every slot before any walk reaches it
    load_entry(4'd0, 8'd5, 17'd65536, 17'h1FFFF, '0, 31'd10, 31'd16);
    load_entry(4'd1, 8'd5, 17'h1FFFF, 17'd1, 31'd2, TIME_MAX, '0);
    load_entry(4'd2, 8'd255, 17'd65535, 17'd65536, '0, TIME_MAX, TIME_MAX);
    load_entry(4'd3, 8'd0, '0, '0, TIME_MAX, '0, 31'd1);
    for (int i = 4; i < TABLE_ENTRIES_DEF; i++) begin
      load_entry(INDEX_W'(i), 8'd5, 17'd65536, 17'd65536, '0, TIME_MAX, TIME_MAX);
    end
    settle();
    write_entry_count(5'd16);

    ask(8'd5, 31'd5, 1'b0, 16'hFFFF);
    ask(8'd5, 31'd21, 1'b1, 16'h0000);
    ask(8'd255, 31'd1, 1'b0, 16'hFFFE);
    ask(8'd255, 31'd1, 1'b0, 16'hFFFF);
    ask(8'd0, 31'd3, 1'b1, 16'h0000);
    ask(8'd5, '0, 1'b0, 16'h0000);
    ask(8'd5, TIME_MAX, 1'b1, 16'h8000);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      count = (count_plan[ph] < 0) ? $urandom_range(0, 31) : count_plan[ph];
      write_entry_count(CFG_W'(count));
      sender_gaps = (ph % 3) != 1;
      sink_stalls = (ph % 4) != 2;
      if (ph == 3) begin
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) settle();
        if ($urandom_range(0, 3) == 0) random_load();
        else random_query();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
